>>> src/dsvr_pkg.sv
// shared types and constants of the deadband step voltage regulator
package dsvr_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned MvW     = 16;
  localparam int unsigned DacW    = 12;
  localparam int unsigned ProdW   = SampleW + MvW;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned StepCntW = 4;

  localparam logic [MvW-1:0]      RefReset    = 16'd5244;
  localparam logic [MvW-1:0]      TargetReset = 16'd2800;
  localparam logic [MvW:0]        BandWidth   = 17'd20;
  localparam logic [MvW-1:0]      DriveStep   = 16'd2;
  localparam logic [MvW-1:0]      DriveMax    = 16'hFFFF;
  localparam logic [DacW-1:0]     DacMax      = 12'hFFF;
  localparam logic [StepCntW-1:0] LastStep    = 4'(DacW - 1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegReference = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTarget    = 1'd1;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic update;
    logic step;
    logic load;
  } dsvr_cmd_t;

endpackage

>>> src/dsvr_ctrl.sv
// control state machine: sequences measure, drive update, division and output
module dsvr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dsvr_pkg::dsvr_cmd_t cmd_o
);
  import dsvr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDivide,
    StDone
  } state_e;

  state_e                state_q, state_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  // commands decoded from state
  assign in_ready_o   = (state_q == StIdle);
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.update = (state_q == StUpdate);
  assign cmd_o.step   = (state_q == StDivide);
  assign cmd_o.load   = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;

  // next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (cmd_o.accept) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        state_d = StDivide;
        cnt_d   = '0;
      end
      StDivide: begin
        if (cnt_q == LastStep) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (cmd_o.load) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/dsvr_datapath.sv
// datapath: config registers, scaling multiply, drive update, serial divider
module dsvr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsvr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsvr_pkg::MvW-1:0]      cfg_data_i,
  input  dsvr_pkg::dsvr_cmd_t           cmd_i,
  input  logic [dsvr_pkg::SampleW-1:0]  sample_i,
  output logic [dsvr_pkg::DacW-1:0]     dac_o,
  output logic [dsvr_pkg::MvW-1:0]      drive_o,
  output logic [dsvr_pkg::MvW-1:0]      meas_o
);
  import dsvr_pkg::*;

  logic [MvW-1:0]   ref_q, target_q;
  logic [MvW-1:0]   drive_q, drive_d;
  logic [MvW-1:0]   meas_q;
  logic [ProdW-1:0] prod;
  logic [MvW-1:0]   rem_q, rem_d;
  logic [DacW-1:0]  quo_q, quo_d;
  logic             sat_q;
  logic [MvW:0]     rem_sh, rem_sub;
  logic             rem_ge;
  logic [DacW-1:0]  dac_q;
  logic [MvW-1:0]   drive_out_q, meas_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= RefReset;
      target_q <= TargetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegReference: ref_q    <= cfg_data_i;
        RegTarget:    target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample scaled to millivolts, taken on accept
  assign prod = ProdW'(sample_i) * ProdW'(ref_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      meas_q <= prod[ProdW-1:SampleW];
    end
  end

  // bang-bang drive update with deadband and saturation
  always_comb begin
    drive_d = drive_q;
    if (meas_q < target_q) begin
      drive_d = (drive_q > DriveMax - DriveStep) ? DriveMax : drive_q + DriveStep;
    end else if ({1'b0, meas_q} > {1'b0, target_q} + BandWidth) begin
      drive_d = (drive_q < DriveStep) ? '0 : drive_q - DriveStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
    end else if (cmd_i.update) begin
      drive_q <= drive_d;
    end
  end

  // restoring divider: drive * 4096 / reference, one quotient bit per step
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, ref_q});
  assign rem_sub = rem_sh - {1'b0, ref_q};
  assign rem_d   = rem_ge ? rem_sub[MvW-1:0] : rem_sh[MvW-1:0];
  assign quo_d   = {quo_q[DacW-2:0], rem_ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      // quotient reaches 4096 exactly when drive >= reference
      rem_q <= drive_d;
      quo_q <= '0;
      sat_q <= (ref_q == '0) || (drive_d >= ref_q);
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dac_q       <= sat_q ? DacMax : quo_q;
      drive_out_q <= drive_q;
      meas_out_q  <= meas_q;
    end
  end

  assign dac_o   = dac_q;
  assign drive_o = drive_out_q;
  assign meas_o  = meas_out_q;

endmodule

>>> src/deadband_step_voltage_regulator.sv
// top level of the deadband step voltage regulator
// an accepted word passes in order through the drive update, the 12-step serial divider and the output register
// a new input word is taken only after the previous word has left the divider
// the next input word is taken while a finished result waits on the output
// reset: asynchronous active low; drive clears to 0, reference 5244, target 2800
module deadband_step_voltage_regulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [dsvr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsvr_pkg::MvW-1:0]       cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dsvr_pkg::InDataW-1:0]   s_axis_tdata,  // sample_code[11:0], zero pad
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dsvr_pkg::OutDataW-1:0]  m_axis_tdata   // dac_code, drive_mv, measured_mv, pad
);
  import dsvr_pkg::*;

  dsvr_cmd_t        cmd;
  logic [DacW-1:0]  dac;
  logic [MvW-1:0]   drive;
  logic [MvW-1:0]   meas;

  // sequencing
  dsvr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  dsvr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sample_i   (s_axis_tdata[SampleW-1:0]),
    .dac_o      (dac),
    .drive_o    (drive),
    .meas_o     (meas)
  );

  // output word packing
  assign m_axis_tdata = {(OutDataW - DacW - 2 * MvW)'(0), meas, drive, dac};

  // a word is in flight for at least the update and first divide cycles
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while previous word still in progress");

  // zero drive yields code zero unless saturated
  a_zero_drive_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[27:12] == '0) && (m_axis_tdata[11:0] != DacMax))
      |-> (m_axis_tdata[11:0] == '0))
    else $error("nonzero converter code for zero drive");

  // load only happens in the done phase, never together with an accept
  a_no_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.accept))
    else $error("output load and input accept in the same cycle");

endmodule
